### sv/hfd_pkg.sv
package hfd_pkg;

	typedef enum logic {
		CMD_HEX2DBL = 1'b0,
		CMD_DBL2HEX = 1'b1
	} cmd_t;

	// Stage 1 to stage 2: decoded operand plus the leading-zero count.
	typedef struct packed {
		logic       cmd;
		logic       sign;
		logic [6:0] exp7;
		logic [55:0] frac;
		logic [5:0] lzc;
		logic       zero;
		logic [10:0] e11;
	} dec_t;

	// Stage 2 to stage 3: normalized hex fraction or finished double-to-hex word.
	typedef struct packed {
		logic        cmd;
		logic        sign;
		logic [10:0] ebias;
		logic [55:0] norm;
		logic        zero;
		logic [63:0] word;
		logic        err;
	} nrm_t;

	function automatic logic [5:0] lzc56(input logic [55:0] f);
		logic [5:0] n;
		logic       found;
		n = 6'd0;
		found = 1'b0;
		for (int i = 55; i >= 0; i--) begin
			if (!found && f[i]) begin
				found = 1'b1;
				n = 6'(55 - i);
			end
		end
		return n;
	endfunction

endpackage

### sv/hfd_norm.sv
module hfd_norm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  hfd_pkg::dec_t     d,
	output logic              vout,
	output hfd_pkg::nrm_t     n_s2
);
	hfd_pkg::nrm_t n;
	logic signed [12:0] biased;
	logic signed [12:0] x;
	logic [55:0] sig;

	always_comb begin
		n = '0;
		n.cmd = d.cmd;
		n.sign = d.sign;
		n.zero = d.zero;
		n.norm = d.frac << d.lzc;
		// Double exponent of the leading one: 4*exp7 - 256 - 1 - lzc + 1023.
		n.ebias = 11'({2'b00, d.exp7, 2'b00} + 11'd766 - {5'd0, d.lzc});
		biased = 13'($signed({2'b00, d.e11}) + 13'sd1);
		x = (biased >>> 2) - 13'sd256 + 13'sd1;
		sig = {3'b000, 1'b1, d.frac[51:0]} << biased[1:0];
		n.err = 1'b0;
		n.word = '0;
		if (d.e11 == 11'h7FF) begin
			n.err = 1'b1;
			n.word = {d.sign, 63'h7FFF_FFFF_FFFF_FFFF};
		end else if (d.e11 == 11'd0) begin
			n.err = (d.frac[51:0] != '0);
		end else if (x > 13'sd63) begin
			n.err = 1'b1;
			n.word = {d.sign, 63'h7FFF_FFFF_FFFF_FFFF};
		end else if (x < -13'sd64) begin
			n.err = 1'b1;
		end else begin
			n.word = {d.sign, 7'(x + 13'sd64), sig};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2 <= n;
		end
	end
endmodule

### sv/hfd_round.sv
module hfd_round (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  hfd_pkg::nrm_t n,
	output logic          vout,
	output logic [63:0]   word_s3,
	output logic          err_s3
);
	logic [63:0] w;
	logic [52:0] mant;
	logic [53:0] inc;
	logic        up;
	logic [10:0] e;

	always_comb begin
		// Leading one at bit 55; keep bits 55..3, round on the three dropped.
		mant = n.norm[55:3];
		up = n.norm[2] & (n.norm[1] | n.norm[0] | mant[0]);
		inc = {1'b0, mant} + {53'd0, up};
		e = n.ebias;
		if (inc[53]) begin
			e = e + 11'd1;
		end
		if (n.cmd == hfd_pkg::CMD_DBL2HEX) begin
			w = n.word;
		end else if (n.zero) begin
			w = '0;
		end else begin
			w = {n.sign, e, inc[53] ? inc[52:1] : inc[51:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s3 <= w;
			err_s3 <= (n.cmd == hfd_pkg::CMD_DBL2HEX) ? n.err : 1'b0;
		end
	end
endmodule

### sv/hex_float_ieee_double_converter_core.sv
// Converts between the 64-bit excess-64 base-16 real and the IEEE-754 double.
// tuser bit 0 picks the direction (0: hex to double, 1: double to hex), tdata is
// the source word. Hex to double normalizes with a leading-zero count and rounds
// to nearest even; a zero fraction gives +0. Double to hex is exact; NaN, infinity
// and overflow raise range_error with a saturated result, underflow with a zero one.
// The block is a three-stage pipeline (decode and leading-zero count, shift and
// exponent, rounding and packing) that accepts one item every cycle unless the
// output is stalled; each item passes through the stage registers in order before
// it is shown at the output. All stages advance together whenever the output
// register is empty or being drained.
module hex_float_ieee_double_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // operand_word[63:0]
	input  logic        s_tuser,   // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // result_word[63:0]
	output logic        m_tuser    // range_error
);
	logic          en;
	logic          v_s1;
	logic          v_s2;
	hfd_pkg::dec_t d_s1;
	hfd_pkg::nrm_t n_s2;

	// The pipeline moves as a whole; a bubble at the output lets it move too.
	assign en = m_tready | ~m_tvalid;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1.cmd <= s_tuser;
			d_s1.sign <= s_tdata[63];
			d_s1.exp7 <= s_tdata[62:56];
			d_s1.frac <= s_tdata[55:0];
			d_s1.lzc <= hfd_pkg::lzc56(s_tdata[55:0]);
			d_s1.zero <= (s_tdata[55:0] == '0);
			d_s1.e11 <= s_tdata[62:52];
		end
	end

	hfd_norm u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s1), .d(d_s1),
		.vout(v_s2), .n_s2(n_s2)
	);

	hfd_round u_round (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_s2), .n(n_s2),
		.vout(m_tvalid), .word_s3(m_tdata), .err_s3(m_tuser)
	);
endmodule

### sv/hfd_checker.sv
module hfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("accepted item did not arrive");
	a_hex_noerr: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser && m_tready ##1 m_tready ##1 m_tready
		|=> !m_tuser)
		else $error("range error in hex to double");
endmodule

bind hex_float_ieee_double_converter_core hfd_checker u_hfd_checker (.*);

### sim/testbench.sv
`timescale 1ns / 100ps

// Scoreboard for the hex-real / IEEE double converter. Each accepted item is
// converted here and queued; each result is checked against the oldest entry.
class conv_scoreboard;
	logic [64:0] expected_q[$];
	int unsigned fail_count;

	// Hex real to double: normalize the 56-bit fraction, round to nearest even.
	function automatic logic [63:0] hex_to_double(logic [63:0] w);
		logic [55:0] frac;
		logic [52:0] mant;
		logic [55:0] rem;
		logic [55:0] half;
		int p;
		int e;
		int d;
		frac = w[55:0];
		if (frac == '0)
			return '0;
		p = 55;
		while (!frac[p])
			p--;
		e = p - 56 + 4 * int'(w[62:56]) - 256;
		if (p > 52) begin
			d = p - 52;
			rem = frac & ((56'd1 << d) - 56'd1);
			half = 56'd1 << (d - 1);
			mant = 53'(frac >> d);
			if (rem > half || (rem == half && mant[0])) begin
				mant = mant + 53'd1;
				// A carry out of the top makes mant zero in 53 bits: bump the exponent.
				if (mant == '0)
					e++;
			end
		end else begin
			mant = 53'(frac << (52 - p));
		end
		return {w[63], 11'(e + 1023), mant[51:0]};
	endfunction

	// Double to hex real: exact, with saturation and a range flag.
	function automatic logic [64:0] double_to_hex(logic [63:0] w);
		logic [10:0] e11;
		logic [55:0] sig;
		int biased;
		int x;
		e11 = w[62:52];
		if (e11 == 11'h7FF)
			return {1'b1, w[63], 63'h7FFF_FFFF_FFFF_FFFF};
		if (e11 == '0)
			return {(w[51:0] != '0), 64'd0};
		biased = int'(e11) + 1;
		x = biased / 4 - 255;
		if (x > 63)
			return {1'b1, w[63], 63'h7FFF_FFFF_FFFF_FFFF};
		if (x < -64)
			return {1'b1, 64'd0};
		sig = {3'b000, 1'b1, w[51:0]} << (biased % 4);
		return {1'b0, w[63], 7'(x + 64), sig};
	endfunction

	function void note_operand(logic cmd, logic [63:0] word);
		if (cmd == hfd_pkg::CMD_HEX2DBL)
			expected_q.push_back({1'b0, hex_to_double(word)});
		else
			expected_q.push_back(double_to_hex(word));
	endfunction

	function void check_result(logic [63:0] word, logic flag);
		logic [64:0] want;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result word %h flag %b", $time, word, flag);
			fail_count++;
			return;
		end
		want = expected_q.pop_front();
		if (word !== want[63:0]) begin
			$display("%0t: result_word expected %h actual %h", $time, want[63:0], word);
			fail_count++;
		end
		if (flag !== want[64]) begin
			$display("%0t: range_error expected %b actual %b", $time, want[64], flag);
			fail_count++;
		end
	endfunction
endclass

module testbench;

	localparam int unsigned CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;

	// Percentages of idle sender cycles and stalled receiver cycles for the phase.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	// Set while the receiver holds off for a long stretch to fill the pipeline.
	bit          hold_off;
	bit          stimulus_done;
	int unsigned cycle_count;

	conv_scoreboard conv_sb;

	hex_float_ieee_double_converter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // operand_word[63:0]
		.s_tuser  (s_tuser),   // command
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // result_word[63:0]
		.m_tuser  (m_tuser)    // range_error
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one item from the falling edge and hold it until the block takes it.
	task automatic send_operand(input logic cmd, input logic [63:0] word);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= word;
		do
			@(posedge clk);
		while (!s_tready);
		conv_sb.note_operand(cmd, word);
		@(negedge clk);
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	// Builds a double with the given sign, biased exponent and random fraction.
	function automatic logic [63:0] make_double(logic sgn, logic [10:0] e11);
		return {sgn, e11, 20'($urandom), $urandom};
	endfunction

	// Builds a hex real whose fraction has a random number of leading zero bits,
	// so every rounding position and the normalization shifter are exercised.
	function automatic logic [63:0] make_hex();
		logic [55:0] frac;
		frac = {24'($urandom), $urandom};
		frac = frac >> $urandom_range(55);
		// Sometimes land the dropped bits exactly on a tie or all ones.
		case ($urandom_range(3))
			0: frac[2:0] = 3'b100;
			1: frac[3:0] = 4'b1111;
			default: ;
		endcase
		return {1'($urandom), 7'($urandom), frac};
	endfunction

	task automatic send_random();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 40)
			send_operand(hfd_pkg::CMD_HEX2DBL, make_hex());
		else if (pick < 45)
			send_operand(hfd_pkg::CMD_HEX2DBL, {$urandom, $urandom});
		else if (pick < 80)
			// Exponents around the hex-real range, where the edges lie.
			send_operand(hfd_pkg::CMD_DBL2HEX, make_double(1'($urandom),
				11'($urandom_range(1023 - 270, 1023 + 260))));
		else if (pick < 95)
			send_operand(hfd_pkg::CMD_DBL2HEX, {$urandom, $urandom});
		else
			send_operand(hfd_pkg::CMD_DBL2HEX, make_double(1'($urandom),
				($urandom_range(1) != 0) ? 11'h7FF : 11'h000));
	endtask

	// Directed items: extremes, zeros, ties, carries and every range boundary.
	task automatic send_directed();
		send_operand(hfd_pkg::CMD_HEX2DBL, 64'h0000_0000_0000_0000);
		send_operand(hfd_pkg::CMD_HEX2DBL, 64'hFF00_0000_0000_0000);  // zero fraction, sign set
		send_operand(hfd_pkg::CMD_HEX2DBL, 64'hFFFF_FFFF_FFFF_FFFF);  // rounds up with carry
		send_operand(hfd_pkg::CMD_HEX2DBL, 64'h0000_0000_0000_0001);
		send_operand(hfd_pkg::CMD_HEX2DBL, 64'h4110_0000_0000_0000);
		send_operand(hfd_pkg::CMD_HEX2DBL, 64'hC180_0000_0000_0004);  // tie to even, kept
		send_operand(hfd_pkg::CMD_HEX2DBL, 64'h4180_0000_0000_000C);  // tie to even, rounded up
		send_operand(hfd_pkg::CMD_HEX2DBL, 64'h7F7F_FFFF_FFFF_FFF0);
		send_operand(hfd_pkg::CMD_DBL2HEX, 64'h0000_0000_0000_0000);
		send_operand(hfd_pkg::CMD_DBL2HEX, 64'h8000_0000_0000_0000);
		send_operand(hfd_pkg::CMD_DBL2HEX, 64'h0000_0000_0000_0001);  // subnormal
		send_operand(hfd_pkg::CMD_DBL2HEX, 64'h800F_FFFF_FFFF_FFFF);
		send_operand(hfd_pkg::CMD_DBL2HEX, 64'h7FF0_0000_0000_0000);  // +infinity
		send_operand(hfd_pkg::CMD_DBL2HEX, 64'hFFF8_0000_0000_0001);  // NaN
		send_operand(hfd_pkg::CMD_DBL2HEX, 64'h3FF0_0000_0000_0000);
		send_operand(hfd_pkg::CMD_DBL2HEX, 64'hFFEF_FFFF_FFFF_FFFF);  // far overflow
		send_operand(hfd_pkg::CMD_DBL2HEX,
			make_double(1'b0, 11'd1023 + 11'd251)); // last in range
		send_operand(hfd_pkg::CMD_DBL2HEX,
			make_double(1'b1, 11'd1023 + 11'd252)); // first overflow
		send_operand(hfd_pkg::CMD_DBL2HEX,
			make_double(1'b0, 11'd1023 - 11'd260)); // last in range
		send_operand(hfd_pkg::CMD_DBL2HEX,
			make_double(1'b1, 11'd1023 - 11'd261)); // first underflow
		send_operand(hfd_pkg::CMD_DBL2HEX, 64'h0010_0000_0000_0000);
	endtask

	// Receiver: random stalls per phase, plus the long hold-off when asked.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !hold_off &&
				!(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			conv_sb.check_result(m_tdata, m_tuser);
	end

	// Waits on the shared cycle counter so the sender keeps pushing against a full pipeline.
	initial begin
		hold_off = 1'b0;
		wait (stimulus_done == 1'b0 && cycle_count > 400);
		hold_off = 1'b1;
		repeat (60) @(posedge clk);
		@(negedge clk);
		hold_off = 1'b0;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		conv_sb = new();
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stimulus_done = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_directed();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			for (int n = 0; n < 470; n++)
				send_random();
		end
		go_idle();
		stimulus_done = 1'b1;

		while (conv_sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (conv_sb.fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
sv/hfd_pkg.sv
sv/hfd_norm.sv
sv/hfd_round.sv
sv/hex_float_ieee_double_converter_core.sv
sv/hfd_checker.sv
sim/testbench.sv
